// File: rtl/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int MAX_LIST_DEF   = 16;
    localparam int ID_SPACE       = 256;
    localparam logic [4:0] LIST_LEN_RESET = 5'd10;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_RANK   = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  player_id;
        logic [30:0] score;
        logic [8:0]  start_rank;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_player;
        logic [8:0] out_rank;
        logic       item_valid;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [30:0] score;
    } entry_t;

    typedef enum logic [2:0] {
        IDX_HOLD  = 3'd0,
        IDX_CLR   = 3'd1,
        IDX_INC   = 3'd2,
        IDX_DEC   = 3'd3,
        IDX_COUNT = 3'd4,
        IDX_START = 3'd5
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_NEXT = 2'd1,
        RD_PREV = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        EK_OK   = 3'd0,
        EK_FULL = 3'd1,
        EK_MISS = 3'd2,
        EK_RANK = 3'd3,
        EK_LIST = 3'd4
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        idx_op_t    idx_op;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        logic       wr_new;
        logic       pos_load;
        logic       k_clr;
        logic       k_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       pres_set;
        logic       pres_clr;
        logic       emit;
        emit_kind_t emit_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       present;
        logic       full;
        logic       start_bad;
        logic       idx_at_count;
        logic       next_at_count;
        logic       idx_at_pos;
        logic       id_match;
        logic       score_less;
        logic       list_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// File: rtl/srt_ram.sv
`timescale 1ns / 1ps

module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/srt_ctrl.sv
`timescale 1ns / 1ps

module srt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srt_pkg::dp_stat_t  stat,
    output srt_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'd1,
        S_DISP    = 13'd2,
        S_FIND_RD = 13'd4,
        S_FIND_EX = 13'd8,
        S_DEL_RD  = 13'd16,
        S_DEL_WR  = 13'd32,
        S_INS_CHK = 13'd64,
        S_SCAN_RD = 13'd128,
        S_SCAN_EX = 13'd256,
        S_INS_SH  = 13'd512,
        S_INS_WR  = 13'd1024,
        S_LIST_RD = 13'd2048,
        S_LIST_EX = 13'd4096
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.idx_op    = srt_pkg::IDX_HOLD;
        cmd.rd_sel    = srt_pkg::RD_IDX;
        cmd.emit_kind = srt_pkg::EK_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.opcode)
                    srt_pkg::OP_UPDATE:
                    begin
                        if (stat.present)
                        begin
                            cmd.idx_op = srt_pkg::IDX_CLR;
                            state_next = S_FIND_RD;
                        end
                        else
                        begin
                            state_next = S_INS_CHK;
                        end
                    end
                    srt_pkg::OP_RANK:
                    begin
                        if (stat.present)
                        begin
                            cmd.idx_op = srt_pkg::IDX_CLR;
                            state_next = S_FIND_RD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = srt_pkg::EK_MISS;
                            state_next    = S_IDLE;
                        end
                    end
                    srt_pkg::OP_LIST:
                    begin
                        if (!stat.start_bad)
                        begin
                            cmd.idx_op = srt_pkg::IDX_START;
                            cmd.k_clr  = 1'b1;
                            state_next = S_LIST_RD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = srt_pkg::EK_MISS;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FIND_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_FIND_EX;
            end
            S_FIND_EX:
            begin
                if (stat.id_match)
                begin
                    if (stat.opcode == srt_pkg::OP_RANK)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = srt_pkg::EK_RANK;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else
                begin
                    cmd.idx_op = srt_pkg::IDX_INC;
                    state_next = S_FIND_RD;
                end
            end
            S_DEL_RD:
            begin
                if (stat.next_at_count)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.pres_clr = 1'b1;
                    state_next   = S_INS_CHK;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srt_pkg::RD_NEXT;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = srt_pkg::IDX_INC;
                state_next = S_DEL_RD;
            end
            S_INS_CHK:
            begin
                if (stat.full)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = srt_pkg::EK_FULL;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_op = srt_pkg::IDX_CLR;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.pos_load = 1'b1;
                    state_next   = S_INS_SH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN_EX;
                end
            end
            S_SCAN_EX:
            begin
                if (stat.score_less)
                begin
                    cmd.pos_load = 1'b1;
                    cmd.idx_op   = srt_pkg::IDX_COUNT;
                    state_next   = S_INS_SH;
                end
                else
                begin
                    cmd.idx_op = srt_pkg::IDX_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_INS_SH:
            begin
                if (stat.idx_at_pos)
                begin
                    if (stat.out_free)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_new    = 1'b1;
                        cmd.cnt_inc   = 1'b1;
                        cmd.pres_set  = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = srt_pkg::EK_OK;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srt_pkg::RD_PREV;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = srt_pkg::IDX_DEC;
                state_next = S_INS_SH;
            end
            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LIST_EX;
            end
            S_LIST_EX:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = srt_pkg::EK_LIST;
                    if (stat.list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_op = srt_pkg::IDX_INC;
                        cmd.k_inc  = 1'b1;
                        state_next = S_LIST_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/srt_dp.sv
`timescale 1ns / 1ps

module srt_dp #(
    parameter int CAPACITY = srt_pkg::CAPACITY_DEF,
    parameter int MAX_LIST = srt_pkg::MAX_LIST_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    input  srt_pkg::in_item_t   in_data,
    input  srt_pkg::ctrl_cmd_t  cmd,
    output srt_pkg::dp_stat_t   stat,
    output logic                out_valid,
    input  logic                out_ready,
    output srt_pkg::out_item_t  out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(MAX_LIST + 1);
    localparam int EW = $bits(srt_pkg::entry_t);

    srt_pkg::in_item_t  in_reg;
    srt_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg;
    logic [4:0]          list_len_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       cnt_reg;
    logic [KW-1:0]       k_reg;
    logic [srt_pkg::ID_SPACE-1:0] present_reg;

    logic [AW-1:0]       rd_addr;
    srt_pkg::entry_t     rd_entry, wr_entry;
    logic [EW-1:0]       rd_word;
    logic [KW-1:0]       len_eff;
    logic [CW-1:0]       idx_inc;
    logic [8:0]          rank_val;

    assign rd_entry = srt_pkg::entry_t'(rd_word);
    assign idx_inc  = idx_reg + CW'(1);
    assign rank_val = 9'(idx_inc);

    always_comb
    begin
        case (cmd.rd_sel)
            srt_pkg::RD_NEXT: rd_addr = AW'(idx_inc);
            srt_pkg::RD_PREV: rd_addr = AW'(idx_reg - CW'(1));
            default:          rd_addr = AW'(idx_reg);
        endcase
    end

    assign wr_entry = cmd.wr_new ? srt_pkg::entry_t'{id: in_reg.player_id,
                                                      score: in_reg.score}
                                 : rd_entry;

    srt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (AW'(idx_reg)),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // clamp list length: zero acts as one, above MAX_LIST saturates
    always_comb
    begin
        if (list_len_reg == 5'd0)
        begin
            len_eff = KW'(1);
        end
        else if (32'(list_len_reg) > MAX_LIST)
        begin
            len_eff = KW'(MAX_LIST);
        end
        else
        begin
            len_eff = KW'(list_len_reg);
        end
    end

    always_comb
    begin
        stat.opcode        = in_reg.opcode;
        stat.present       = present_reg[in_reg.player_id];
        stat.full          = (32'(cnt_reg) >= CAPACITY);
        stat.start_bad     = (in_reg.start_rank == 9'd0) ||
                             (32'(in_reg.start_rank) > 32'(cnt_reg));
        stat.idx_at_count  = (idx_reg == cnt_reg);
        stat.next_at_count = (32'(idx_reg) + 32'd1 >= 32'(cnt_reg));
        stat.idx_at_pos    = (idx_reg == pos_reg);
        stat.id_match      = (rd_entry.id == in_reg.player_id);
        stat.score_less    = (rd_entry.score < in_reg.score);
        stat.list_last     = (32'(k_reg) + 32'd1 == 32'(len_eff)) ||
                             (idx_inc == cnt_reg);
        stat.out_free      = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (cmd.idx_op)
            srt_pkg::IDX_CLR:   idx_next = '0;
            srt_pkg::IDX_INC:   idx_next = idx_inc;
            srt_pkg::IDX_DEC:   idx_next = idx_reg - CW'(1);
            srt_pkg::IDX_COUNT: idx_next = cnt_reg;
            srt_pkg::IDX_START: idx_next = CW'(32'(in_reg.start_rank) - 32'd1);
            default:            idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        out_next = '0;
        out_next.last = 1'b1;
        case (cmd.emit_kind)
            srt_pkg::EK_FULL: out_next.status = srt_pkg::ST_FULL;
            srt_pkg::EK_MISS: out_next.status = srt_pkg::ST_NOT_FOUND;
            srt_pkg::EK_RANK:
            begin
                out_next.out_player = in_reg.player_id;
                out_next.out_rank   = rank_val;
                out_next.item_valid = 1'b1;
            end
            srt_pkg::EK_LIST:
            begin
                out_next.out_player = rd_entry.id;
                out_next.out_rank   = rank_val;
                out_next.item_valid = 1'b1;
                out_next.last       = stat.list_last;
            end
            default: out_next.status = srt_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
        if (cmd.pos_load)
        begin
            pos_reg <= idx_reg;
        end
        idx_reg <= idx_next;
        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            list_len_reg  <= srt_pkg::LIST_LEN_RESET;
            cnt_reg       <= '0;
            present_reg   <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                list_len_reg <= cfg_wr_data;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.pres_set)
            begin
                present_reg[in_reg.player_id] <= 1'b1;
            end
            else if (cmd.pres_clr)
            begin
                present_reg[in_reg.player_id] <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/score_ranking_table.sv
`timescale 1ns / 1ps

// Score ranking table: player ids kept in descending score order, earlier
// writes first among equal scores.
// Input channel (in_valid/in_ready/in_data) carries one transaction per
// command: update, rank query or list query. Output channel
// (out_valid/out_ready/out_data) returns one result per update or rank
// query, and one to list_length results (clamped to 1..MAX_LIST) per list
// query, the final one marked by last.
// One command is worked at a time; in_ready is high only while idle.
// Entries live in one RAM with a registered read, and every table access
// goes through the shared index counter:
//   rank query: scan to the player,
//   list query: one read per emitted rank,
//   update: scan to the old entry, shift the tail down, scan to the
//   insert point, shift the tail up.
// Results sit in an output register; a stalled receiver holds the
// controller in its emit step, and no state changes until it is taken.
// Reset clears the entry count, the presence bits and sets list_length to
// 10; RAM contents need no clearing since only entries below the count
// are ever read. cfg_wr_en writes list_length immediately.
module score_ranking_table #(
    parameter int CAPACITY = srt_pkg::CAPACITY_DEF,
    parameter int MAX_LIST = srt_pkg::MAX_LIST_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  srt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output srt_pkg::out_item_t out_data
);

    srt_pkg::ctrl_cmd_t cmd;
    srt_pkg::dp_stat_t  stat;

    // sequencer: walks scans and shifts one entry at a time
    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table RAM, counters, presence bits and output register
    srt_dp #(
        .CAPACITY (CAPACITY),
        .MAX_LIST (MAX_LIST)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

`ifndef SYNTHESIS
    // one command at a time: after an accepted transaction, hold off input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while busy");

    // results built from RAM data rely on the read data being held
    a_no_read_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.emit))
        else $error("RAM read issued while emitting");

    // never grow the table past capacity
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("insert into full table");
`endif

endmodule

// File: tb/sv/score_ranking_table_test.sv
`timescale 1ns / 1ps

module score_ranking_table_test;

    localparam int CAP       = 256;
    localparam int MAXL      = 16;
    // Longest quiet stretch: a full-table update plus both sides' gaps.
    // Take it several times over.
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [4:0]         cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    srt_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    srt_pkg::out_item_t out_data;

    score_ranking_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    always #2 clk = ~clk;

    // Shadow of the table, mirrored from what each accepted command does.
    logic [7:0]  shadow_ids [CAP];
    logic [30:0] shadow_scores [CAP];
    int          shadow_count;
    bit          shadow_present [256];
    logic [4:0]  shadow_list_len;

    srt_pkg::in_item_t  pending_cmds[$];
    srt_pkg::out_item_t expected_results[$];

    int  error_count;
    int  results_seen;
    int  quiet_cycles;
    int  send_gap;
    int  recv_gap;
    bit  hold_sender;
    bit  stim_done;

    task automatic report_mismatch(input string what);
        $display("MISMATCH t=%0t: %s", $time, what);
        error_count++;
    endtask

    function automatic srt_pkg::out_item_t make_result(input logic [7:0] p,
                                                       input logic [8:0] r,
                                                       input logic v, input logic [1:0] s,
                                                       input logic l);
        srt_pkg::out_item_t res;
        res.out_player = p;
        res.out_rank = r;
        res.item_valid = v;
        res.status = s;
        res.last = l;
        return res;
    endfunction

    function automatic int locate_player(input logic [7:0] id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_ids[i] == id)
                return i;
        return shadow_count;
    endfunction

    // Apply one command to the shadow table and queue what it should return.
    task automatic predict_ranking(input srt_pkg::in_item_t cmd);
        int pos;
        int len;
        int n;
        int first;
        if (cmd.opcode == srt_pkg::OP_UPDATE)
        begin
            if (shadow_present[cmd.player_id])
            begin
                pos = locate_player(cmd.player_id);
                for (int i = pos + 1; i < shadow_count; i++)
                begin
                    shadow_ids[i-1] = shadow_ids[i];
                    shadow_scores[i-1] = shadow_scores[i];
                end
                shadow_count--;
                shadow_present[cmd.player_id] = 1'b0;
            end
            if (shadow_count >= CAP)
            begin
                expected_results.push_back(make_result(8'd0, 9'd0, 1'b0,
                                                       srt_pkg::ST_FULL, 1'b1));
                return;
            end
            pos = shadow_count;
            for (int i = 0; i < shadow_count; i++)
                if (shadow_scores[i] < cmd.score)
                begin
                    pos = i;
                    break;
                end
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_ids[i] = shadow_ids[i-1];
                shadow_scores[i] = shadow_scores[i-1];
            end
            shadow_ids[pos] = cmd.player_id;
            shadow_scores[pos] = cmd.score;
            shadow_count++;
            shadow_present[cmd.player_id] = 1'b1;
            expected_results.push_back(make_result(8'd0, 9'd0, 1'b0, srt_pkg::ST_OK, 1'b1));
        end
        else if (cmd.opcode == srt_pkg::OP_RANK)
        begin
            pos = shadow_present[cmd.player_id] ? locate_player(cmd.player_id)
                                                : shadow_count;
            if (pos < shadow_count)
                expected_results.push_back(make_result(cmd.player_id, 9'(pos + 1), 1'b1,
                                                       srt_pkg::ST_OK, 1'b1));
            else
                expected_results.push_back(make_result(8'd0, 9'd0, 1'b0,
                                                       srt_pkg::ST_NOT_FOUND, 1'b1));
        end
        else if (cmd.opcode == srt_pkg::OP_LIST)
        begin
            len = int'(shadow_list_len);
            if (len < 1) len = 1;
            if (len > MAXL) len = MAXL;
            first = int'(cmd.start_rank);
            if (first == 0 || first > shadow_count)
            begin
                expected_results.push_back(make_result(8'd0, 9'd0, 1'b0,
                                                       srt_pkg::ST_NOT_FOUND, 1'b1));
                return;
            end
            n = shadow_count - first + 1;
            if (n > len) n = len;
            for (int k = 0; k < n; k++)
                expected_results.push_back(make_result(shadow_ids[first-1+k],
                                                       9'(first + k), 1'b1,
                                                       srt_pkg::ST_OK, (k + 1 == n)));
        end
        // the unused opcode does nothing at all
    endtask

    // Driver: pop the next pending command after a random gap, hold it
    // until the transaction completes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_ranking(in_data);
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            else if (!in_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (!hold_sender && pending_cmds.size() > 0)
                begin
                    in_data <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    // and draw a fresh stall for the receiver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", out_data));
                else
                begin
                    srt_pkg::out_item_t want;
                    want = expected_results.pop_front();
                    if (out_data.out_player !== want.out_player)
                        report_mismatch($sformatf("out_player %0d want %0d",
                                                  out_data.out_player, want.out_player));
                    if (out_data.out_rank !== want.out_rank)
                        report_mismatch($sformatf("out_rank %0d want %0d",
                                                  out_data.out_rank, want.out_rank));
                    if (out_data.item_valid !== want.item_valid)
                        report_mismatch($sformatf("item_valid %0b want %0b",
                                                  out_data.item_valid, want.item_valid));
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d want %0d",
                                                  out_data.status, want.status));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last %0b want %0b",
                                                  out_data.last, want.last));
                end
                recv_gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (rst_n && !stim_done)
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic srt_pkg::in_item_t make_cmd(input logic [1:0] op,
                                                   input logic [7:0] id,
                                                   input logic [30:0] sc,
                                                   input logic [8:0] st);
        srt_pkg::in_item_t c;
        c.opcode = op;
        c.player_id = id;
        c.score = sc;
        c.start_rank = st;
        return c;
    endfunction

    // Random score: mostly a narrow range so ties happen often.
    function automatic logic [30:0] pick_score();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 7));
            1: return 31'($urandom_range(0, 200));
            2: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            default: return 31'($urandom());
        endcase
    endfunction

    // Wait until the block has returned everything and gone quiet.
    task automatic wait_for_drain();
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write list_length; only call with the block idle.
    task automatic write_list_len(input logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_list_len = val;
        @(posedge clk);
    endtask

    task automatic queue_random(input int n, input int id_span);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE,
                                                8'($urandom_range(0, id_span)),
                                                pick_score(), 9'($urandom())));
            else if (r < 72)
                pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK,
                                                8'($urandom_range(0, id_span)),
                                                31'($urandom()), 9'($urandom())));
            else if (r < 97)
                pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'($urandom()),
                                       31'($urandom()),
                                       ($urandom_range(0, 5) == 0) ? 9'($urandom())
                                       : 9'($urandom_range(0, shadow_count + 3))));
            else
                pending_cmds.push_back(make_cmd(2'd3, 8'($urandom()), 31'($urandom()),
                                                9'($urandom())));
        end
    endtask

    initial
    begin
        logic [4:0] settings [5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5};
        error_count = 0;
        results_seen = 0;
        quiet_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_sender = 1'b0;
        stim_done = 1'b0;
        shadow_count = 0;
        shadow_list_len = srt_pkg::LIST_LEN_RESET;
        foreach (shadow_present[i]) shadow_present[i] = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table queries, field extremes, ties, re-update,
        // every opcode, list start at zero and beyond the count.
        pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK, 8'd0, 31'd0, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'd1));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd0, 31'd0, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd255, 31'h7FFF_FFFF, 9'h1FF));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd7, 31'd100, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd8, 31'd100, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd9, 31'd100, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd7, 31'd100, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd0, 31'd500, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK, 8'd7, 31'd0, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK, 8'd255, 31'd0, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK, 8'd200, 31'd0, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'hFF, 31'h7FFF_FFFF, 9'd1));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'd5));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'd6));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'h1FF));
        pending_cmds.push_back(make_cmd(2'd3, 8'd42, 31'd1, 9'd1));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK, 8'd42, 31'd0, 9'd0));
        wait_for_drain();

        // Random phases across list_length settings, alternating few ids (so hits dominate) and the full id range.
        foreach (settings[s])
        begin
            write_list_len(settings[s]);
            queue_random(11, (s % 2) ? 255 : 31);
            if (s == 2)
            begin
                // Hold the sender until every expected result is back.
                while (pending_cmds.size() > 5) @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_results.size() > 0) @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_for_drain();
        end

        // Fill the table to capacity, then re-update a player in the full table and list the tail ranks.
        write_list_len(5'd16);
        for (int id = 0; id < 256; id++)
            pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'(id),
                                            31'($urandom_range(0, 40)), 9'($urandom())));
        wait_for_drain();
        pending_cmds.push_back(make_cmd(srt_pkg::OP_UPDATE, 8'd3, 31'd7, 9'd0));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'd256));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_LIST, 8'd0, 31'd0, 9'd241));
        pending_cmds.push_back(make_cmd(srt_pkg::OP_RANK, 8'd3, 31'd0, 9'd0));
        queue_random(20, 255);
        wait_for_drain();

        stim_done = 1'b1;
        $display("Covered updates, rank and list queries over %0d results,", results_seen);
        $display("list lengths 0..31, ties, re-updates and a full table.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
rtl/srt_pkg.sv
rtl/srt_ram.sv
rtl/srt_ctrl.sv
rtl/srt_dp.sv
rtl/score_ranking_table.sv
tb/sv/score_ranking_table_test.sv
